// ----- src/assert_macros.svh -----
// Assertion macros for the checker module tbht_checker.
// Both sample on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/tbht_pkg.sv -----
package tbht_pkg;

  localparam logic [1:0] OP_DEFINE     = 2'd0;
  localparam logic [1:0] OP_ACTIVATE   = 2'd1;
  localparam logic [1:0] OP_DEACTIVATE = 2'd2;
  localparam logic [1:0] OP_TOUCH      = 2'd3;

  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] STAT_FIRED      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_HANDLER = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_INACTIVE   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DEFINED    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd4;

  localparam int INDEX_W    = 4;
  localparam int OUT_DATA_W = 8;
  localparam int MENU_W     = 8;
  localparam int ID_W       = 4;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = 5;

  // Bit positions of the flags at the low end of a packed table entry.
  localparam int ACTIVE_BIT  = 0;
  localparam int HANDLER_BIT = 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic shift;
    logic write;
    logic set_active;
    logic clear_active;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic handler;
    logic active;
  } hit_t;

endpackage

// ----- src/tbht_cell.sv -----
module tbht_cell #(
  parameter int ENTRY_W = 58
) (
  input  logic                clk_i,
  input  tbht_pkg::cell_ctrl_t ctrl_i,
  input  logic [ENTRY_W-1:0]  entry_i,
  input  logic [ENTRY_W-1:0]  wr_entry_i,
  output logic [ENTRY_W-1:0]  entry_o
);
  import tbht_pkg::*;

  logic [ENTRY_W-1:0] entry_q;
  logic [ENTRY_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = entry_i;
    end else if (ctrl_i.write) begin
      entry_d = wr_entry_i;
    end else if (ctrl_i.set_active) begin
      entry_d[ACTIVE_BIT] = 1'b1;
    end else if (ctrl_i.clear_active) begin
      entry_d[ACTIVE_BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- src/tbht_hit.sv -----
module tbht_hit #(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 4 * COORD_BITS + 10
) (
  input  logic [ENTRY_W-1:0]          entry_i,
  input  logic [COORD_BITS-1:0]       px_i,
  input  logic [COORD_BITS-1:0]       py_i,
  input  logic [tbht_pkg::MENU_W-1:0] menu_i,
  output tbht_pkg::hit_t              hit_o
);
  import tbht_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [MENU_W-1:0]     menu;
    logic                  handler;
    logic                  active;
  } entry_t;

  entry_t              ent;
  logic [COORD_BITS:0] right;
  logic [COORD_BITS:0] bottom;

  assign ent    = entry_t'(entry_i);
  assign right  = {1'b0, ent.x} + {1'b0, ent.w};
  assign bottom = {1'b0, ent.y} + {1'b0, ent.h};

  assign hit_o.hit = (px_i >= ent.x) && ({1'b0, px_i} <= right) &&
                     (py_i >= ent.y) && ({1'b0, py_i} <= bottom) &&
                     (ent.menu == menu_i);
  assign hit_o.handler = ent.handler;
  assign hit_o.active  = ent.active;

endmodule

// ----- src/touch_button_hit_table.sv -----
// Touch button hit table.
// Input items arrive on the s_axis channel and carry one of four opcodes:
// define, activate, deactivate all and touch. Results leave on the m_axis
// channel with the button index in tdata, the status in tuser and tlast on
// the final result caused by one input item. The current menu is written
// through the cfg channel, which is always ready.
// The buttons live in a ring of cells. A define writes the next free cell and
// its result appears in the cycle after the item is accepted. A touch rotates
// the ring once, testing one button per cycle at the head cell unless the
// scan pauses for the output register, and then flushes before the next item
// is accepted. Activate and deactivate all give no result.
// A hit is held back one step so that tlast can be set on the last one.
// When the receiver stalls, the finished result waits in the output register
// and the scan pauses only when a further result needs that register.
// Reset empties the table, clears the last hit and selects menu zero.
module touch_button_hit_table #(
  parameter int MAX_BUTTONS = 16,
  parameter int COORD_BITS  = 12,
  localparam int IN_BITS    = 4 * COORD_BITS + 15,
  localparam int DATA_W     = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode, pos_x, pos_y, box_width, box_height, menu_id, has_handler, button_id
  input  logic [DATA_W-1:0]                 s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // button_index
  output logic [tbht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [tbht_pkg::STATUS_W-1:0]     m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbht_pkg::MENU_W-1:0]       cfg_data_i
);
  import tbht_pkg::*;

  localparam int IDX_W   = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int CNT_W   = $clog2(MAX_BUTTONS + 1);
  localparam int CMP_W   = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int ENTRY_W = 4 * COORD_BITS + MENU_W + 2;
  localparam int OFF_X   = 2;
  localparam int OFF_Y   = OFF_X + COORD_BITS;
  localparam int OFF_W   = OFF_Y + COORD_BITS;
  localparam int OFF_H   = OFF_W + COORD_BITS;
  localparam int OFF_M   = OFF_H + COORD_BITS;
  localparam int OFF_HND = OFF_M + MENU_W;
  localparam int OFF_ID  = OFF_HND + 1;

  logic [1:0]            in_op;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic [COORD_BITS-1:0] in_w;
  logic [COORD_BITS-1:0] in_h;
  logic [MENU_W-1:0]     in_menu;
  logic                  in_hnd;
  logic [ID_W-1:0]       in_id;

  assign in_op   = s_axis_tdata[1:0];
  assign in_x    = s_axis_tdata[OFF_X +: COORD_BITS];
  assign in_y    = s_axis_tdata[OFF_Y +: COORD_BITS];
  assign in_w    = s_axis_tdata[OFF_W +: COORD_BITS];
  assign in_h    = s_axis_tdata[OFF_H +: COORD_BITS];
  assign in_menu = s_axis_tdata[OFF_M +: MENU_W];
  assign in_hnd  = s_axis_tdata[OFF_HND];
  assign in_id   = s_axis_tdata[OFF_ID +: ID_W];

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      last_hit_q, last_hit_d;
  logic [IDX_W-1:0]      scan_idx_q, scan_idx_d;
  logic [RES_W-1:0]      nres_q, nres_d;
  logic [MENU_W-1:0]     menu_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic                  pend_valid_q, pend_valid_d;
  logic [INDEX_W-1:0]    pend_idx_q, pend_idx_d;
  logic [STATUS_W-1:0]   pend_stat_q, pend_stat_d;
  logic                  m_valid_q;
  logic [INDEX_W-1:0]    m_idx_q;
  logic [STATUS_W-1:0]   m_stat_q;
  logic                  m_last_q;

  logic                  out_free;
  logic                  in_fire;
  logic                  load;
  logic [INDEX_W-1:0]    ld_idx;
  logic [STATUS_W-1:0]   ld_stat;
  logic                  ld_last;
  logic                  do_write;
  logic                  do_set;
  logic                  do_clear;
  logic                  do_shift;
  logic                  match;
  logic                  emit;
  logic [STATUS_W-1:0]   hit_stat;

  logic [ENTRY_W-1:0]    wr_entry;
  logic [ENTRY_W-1:0]    cell_out [MAX_BUTTONS];
  cell_ctrl_t            cell_ctrl [MAX_BUTTONS];
  hit_t                  head_hit;

  assign wr_entry = {in_x, in_y, in_w, in_h, in_menu, in_hnd, 1'b0};

  for (genvar k = 0; k < MAX_BUTTONS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_BUTTONS;

    assign cell_ctrl[k].shift        = do_shift;
    assign cell_ctrl[k].write        = do_write && (count_q == CNT_W'(k));
    assign cell_ctrl[k].set_active   = do_set && (CMP_W'(in_id) == CMP_W'(k));
    assign cell_ctrl[k].clear_active = do_clear;

    tbht_cell #(
      .ENTRY_W(ENTRY_W)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl[k]),
      .entry_i   (cell_out[NXT]),
      .wr_entry_i(wr_entry),
      .entry_o   (cell_out[k])
    );
  end

  tbht_hit #(
    .COORD_BITS(COORD_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_hit (
    .entry_i(cell_out[0]),
    .px_i   (px_q),
    .py_i   (py_q),
    .menu_i (menu_q),
    .hit_o  (head_hit)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign match = (CNT_W'(scan_idx_q) < count_q) && head_hit.hit;
  assign emit  = match && (CNT_W'(scan_idx_q) != last_hit_q) &&
                 (nres_q < RES_W'(MAX_RESULTS));

  always_comb begin
    if (!head_hit.handler) begin
      hit_stat = STAT_NO_HANDLER;
    end else if (!head_hit.active) begin
      hit_stat = STAT_INACTIVE;
    end else begin
      hit_stat = STAT_FIRED;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    last_hit_d   = last_hit_q;
    scan_idx_d   = scan_idx_q;
    nres_d       = nres_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_stat_d  = pend_stat_q;
    load         = 1'b0;
    ld_idx       = pend_idx_q;
    ld_stat      = pend_stat_q;
    ld_last      = 1'b0;
    do_write     = 1'b0;
    do_set       = 1'b0;
    do_clear     = 1'b0;
    do_shift     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_DEFINE: begin
              load    = 1'b1;
              ld_last = 1'b1;
              if (count_q == CNT_W'(MAX_BUTTONS)) begin
                ld_idx  = '0;
                ld_stat = STAT_FULL;
              end else begin
                ld_idx   = INDEX_W'(count_q);
                ld_stat  = STAT_DEFINED;
                do_write = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            OP_ACTIVATE: begin
              do_set = CMP_W'(in_id) < CMP_W'(count_q);
            end
            OP_DEACTIVATE: begin
              do_clear = 1'b1;
            end
            OP_TOUCH: begin
              state_d    = S_SCAN;
              scan_idx_d = '0;
              nres_d     = '0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!(emit && pend_valid_q) || out_free) begin
          do_shift   = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
          if (match) begin
            last_hit_d = CNT_W'(scan_idx_q);
          end
          if (emit) begin
            load         = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_idx_d   = INDEX_W'(scan_idx_q);
            pend_stat_d  = hit_stat;
            nres_d       = nres_q + 1'b1;
          end
          if (scan_idx_q == IDX_W'(MAX_BUTTONS - 1)) begin
            scan_idx_d = '0;
            state_d    = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          load         = 1'b1;
          ld_last      = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      last_hit_q   <= CNT_W'(MAX_BUTTONS);
      scan_idx_q   <= '0;
      nres_q       <= '0;
      menu_q       <= '0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      last_hit_q   <= last_hit_d;
      scan_idx_q   <= scan_idx_d;
      nres_q       <= nres_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_valid_i) begin
        menu_q <= cfg_data_i;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_stat_q <= pend_stat_d;
    if (in_fire) begin
      px_q <= in_x;
      py_q <= in_y;
    end
    if (load) begin
      m_idx_q  <= ld_idx;
      m_stat_q <= ld_stat;
      m_last_q <= ld_last;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_idx_q);
  assign m_axis_tuser  = m_stat_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- src/tbht_checker.sv -----
`include "assert_macros.svh"

module tbht_checker #(
  parameter int COORD_BITS = 12,
  localparam int IN_BITS   = 4 * COORD_BITS + 15,
  localparam int DATA_W    = ((IN_BITS + 7) / 8) * 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [DATA_W-1:0]               s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tbht_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [tbht_pkg::STATUS_W-1:0]   m_axis_tuser,
  input logic                            m_axis_tlast
);
  import tbht_pkg::*;

  logic in_silent;

  assign in_silent = s_axis_tvalid && s_axis_tready &&
                     ((s_axis_tdata[1:0] == OP_ACTIVATE) ||
                      (s_axis_tdata[1:0] == OP_DEACTIVATE));

  // A stalled result keeps its contents.
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // A define gives exactly one result, so it always closes its run.
  `ASSERT_SAME(a_define_last,
    m_axis_tvalid && ((m_axis_tuser == STAT_DEFINED) || (m_axis_tuser == STAT_FULL)),
    m_axis_tlast)

  // A full table reports button index zero.
  `ASSERT_SAME(a_full_index, m_axis_tvalid && (m_axis_tuser == STAT_FULL),
    m_axis_tdata == '0)

  // Activate and deactivate all never produce a result.
  `ASSERT_NEXT(a_silent_ops, in_silent && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind touch_button_hit_table tbht_checker #(
  .COORD_BITS(COORD_BITS)
) u_tbht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ----- tb/sv/tb_touch_button_hit_table.sv -----
module tb_touch_button_hit_table;
  import tbht_pkg::*;

  localparam int TABLE_SIZE   = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 3000;

  typedef struct packed {
    logic        pad;
    logic [3:0]  button_id;
    logic        has_handler;
    logic [7:0]  menu_id;
    logic [11:0] box_height;
    logic [11:0] box_width;
    logic [11:0] pos_y;
    logic [11:0] pos_x;
    logic [1:0]  opcode;
  } command_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic [7:0]  menu;
    bit          handler;
    bit          active;
  } button_t;

  typedef struct {
    logic [INDEX_W-1:0]  index;
    logic [STATUS_W-1:0] status;
    logic                last_of_run;
  } hit_result_t;

  class hit_table_scoreboard;
    button_t     buttons[TABLE_SIZE];
    int unsigned count;
    int unsigned last_hit;
    logic [7:0]  menu_sel;
    hit_result_t expected_q[$];
    int unsigned errors;

    function new();
      count    = 0;
      last_hit = TABLE_SIZE;
      menu_sel = '0;
      errors   = 0;
    endfunction

    function void apply_command(command_t c);
      hit_result_t r;
      hit_result_t run[$];
      logic [STATUS_W-1:0] st;
      case (c.opcode)
        OP_DEFINE: begin
          r.last_of_run = 1'b1;
          if (count >= TABLE_SIZE) begin
            r.index  = '0;
            r.status = STAT_FULL;
          end else begin
            buttons[count].x       = c.pos_x;
            buttons[count].y       = c.pos_y;
            buttons[count].w       = c.box_width;
            buttons[count].h       = c.box_height;
            buttons[count].menu    = c.menu_id;
            buttons[count].handler = c.has_handler;
            buttons[count].active  = 1'b0;
            r.index  = INDEX_W'(count);
            r.status = STAT_DEFINED;
            count++;
          end
          expected_q.push_back(r);
        end
        OP_ACTIVATE: begin
          if (c.button_id < count) buttons[c.button_id].active = 1'b1;
        end
        OP_DEACTIVATE: begin
          for (int i = 0; i < count; i++) buttons[i].active = 1'b0;
        end
        default: begin
          for (int i = 0; i < count; i++) begin
            if (int'(c.pos_x) >= int'(buttons[i].x) &&
                int'(c.pos_x) <= int'(buttons[i].x) + int'(buttons[i].w) &&
                int'(c.pos_y) >= int'(buttons[i].y) &&
                int'(c.pos_y) <= int'(buttons[i].y) + int'(buttons[i].h) &&
                buttons[i].menu == menu_sel) begin
              if (i != last_hit && run.size() < MAX_RESULTS) begin
                if (!buttons[i].handler) st = STAT_NO_HANDLER;
                else if (!buttons[i].active) st = STAT_INACTIVE;
                else st = STAT_FIRED;
                r.index       = INDEX_W'(i);
                r.status      = st;
                r.last_of_run = 1'b0;
                run.push_back(r);
              end
              last_hit = i;
            end
          end
          if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
          foreach (run[k]) expected_q.push_back(run[k]);
        end
      endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                               logic last_of_run);
      hit_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: button_index %0d status %0d last_of_run %0b",
               data, status, last_of_run);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== OUT_DATA_W'(e.index)) begin
        $error("button_index: expected %0d, got %0d", e.index, data);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (last_of_run !== e.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", e.last_of_run, last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [MENU_W-1:0]     cfg_data_i;

  hit_table_scoreboard sb = new();
  int unsigned results_seen = 0;
  bit          sender_busy = 1'b1;
  logic [7:0]  phase_menu[PHASES] = '{8'hFF, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h5A};

  touch_button_hit_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic command_t base_command(logic [1:0] op);
    command_t c;
    c        = {$urandom, $urandom};
    c.pad    = 1'b0;
    c.opcode = op;
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!sender_busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Touch points mostly land in or next to a defined button so that the scan
  // finds hits; the rest go to the screen centre or anywhere on the screen.
  function automatic command_t random_command(logic [7:0] menu);
    command_t    c;
    int unsigned r;
    int unsigned k;
    int unsigned px;
    int unsigned py;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      c = base_command(OP_DEFINE);
      k = $urandom_range(0, 5);
      if (k < 3) c.menu_id = menu;
      else if (k == 3) c.menu_id = 8'h00;
      else if (k == 4) c.menu_id = 8'hFF;
      k = $urandom_range(0, 3);
      if (k < 2) begin
        c.pos_x      = 12'($urandom_range(0, 2048));
        c.pos_y      = 12'($urandom_range(0, 2048));
        c.box_width  = 12'($urandom_range(2048 - c.pos_x, 4095));
        c.box_height = 12'($urandom_range(2048 - c.pos_y, 4095));
      end else if (k == 2) begin
        c.box_width  = 12'($urandom_range(0, 200));
        c.box_height = 12'($urandom_range(0, 200));
      end
    end else if (r < 24) begin
      c = base_command(OP_ACTIVATE);
      if (sb.count > 0 && $urandom_range(0, 9) < 7)
        c.button_id = 4'($urandom_range(0, sb.count - 1));
    end else if (r < 30) begin
      c = base_command(OP_DEACTIVATE);
    end else begin
      c = base_command(OP_TOUCH);
      k = $urandom_range(0, 99);
      if (sb.count > 0 && k < 70) begin
        r = $urandom_range(0, sb.count - 1);
        if (k < 45) begin
          px = sb.buttons[r].x + $urandom_range(0, sb.buttons[r].w);
          py = sb.buttons[r].y + $urandom_range(0, sb.buttons[r].h);
        end else if (k < 58) begin
          px = sb.buttons[r].x + sb.buttons[r].w;
          py = sb.buttons[r].y + sb.buttons[r].h;
        end else begin
          px = sb.buttons[r].x + sb.buttons[r].w + 1;
          py = (sb.buttons[r].y == 0) ? 0 : sb.buttons[r].y - 1;
        end
        c.pos_x = (px > 4095) ? 12'hFFF : 12'(px);
        c.pos_y = (py > 4095) ? 12'hFFF : 12'(py);
      end else if (k < 80) begin
        c.pos_x = 12'd2048;
        c.pos_y = 12'd2048;
      end
    end
    return c;
  endfunction

  task automatic send_command(input command_t c);
    int unsigned gap;
    s_axis_tdata  <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_command(c);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic define_button(input int x, input int y, input int w, input int h,
                               input logic [7:0] menu, input bit handler);
    command_t c;
    c             = base_command(OP_DEFINE);
    c.pos_x       = 12'(x);
    c.pos_y       = 12'(y);
    c.box_width   = 12'(w);
    c.box_height  = 12'(h);
    c.menu_id     = menu;
    c.has_handler = handler;
    send_command(c);
  endtask

  task automatic touch_at(input int x, input int y);
    command_t c;
    c       = base_command(OP_TOUCH);
    c.pos_x = 12'(x);
    c.pos_y = 12'(y);
    send_command(c);
  endtask

  task automatic activate(input int id);
    command_t c;
    c           = base_command(OP_ACTIVATE);
    c.button_id = 4'(id);
    send_command(c);
  endtask

  task automatic write_menu(input logic [7:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.menu_sel = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // A touch that hits nothing leaves no result behind, so the scan may still
  // be running after the last expected result has arrived.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      results_seen++;
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned cycle_count;
    int unsigned r;
    bit          long_hold_done;
    m_axis_tready  = 1'b0;
    stall_left     = 0;
    cycle_count    = 0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle_count++;
      if (!long_hold_done && results_seen >= 30) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end
      if (stall_left == 0 && (cycle_count / 150) % 2 == 1) begin
        r = $urandom_range(0, 99);
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 30) stall_left = $urandom_range(10, 40);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** touch_button_hit_table: FAILED **");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_menu(8'h00);

    touch_at(10, 10);
    activate(15);
    define_button(0, 0, 4095, 4095, 8'h00, 1'b1);
    define_button(4095, 4095, 4095, 4095, 8'h00, 1'b0);
    define_button(100, 200, 0, 0, 8'h00, 1'b1);
    define_button(1000, 1000, 500, 300, 8'hFF, 1'b1);
    touch_at(4095, 4095);
    touch_at(100, 200);
    touch_at(5, 5);
    touch_at(5, 5);
    activate(0);
    activate(1);
    activate(2);
    activate(15);
    touch_at(100, 200);
    touch_at(1200, 1100);
    touch_at(4095, 4095);
    send_command(base_command(OP_DEACTIVATE));
    touch_at(100, 200);
    touch_at(101, 200);
    touch_at(0, 0);
    touch_at(4095, 0);
    activate(3);
    settle();

    phase_menu[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < PHASES; p++) begin
      write_menu(phase_menu[p]);
      sender_busy = (p % 2 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_command(random_command(phase_menu[p]));
      settle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("** touch_button_hit_table: PASSED **");
    else
      $display("** touch_button_hit_table: FAILED **");
    $finish;
  end

endmodule
